// ----- design/scs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the particle versus moving sphere
// velocity reflection pipeline.
// ----------------------------------------------------------------------------
package scs_pkg;

    // Quotient bits of the correction term: q <= 2|w| < 2^34
    localparam int unsigned QBITS = 35;
    // Numerator width: 2 |w.d| |d_i| < 2^96
    localparam int unsigned NUM_W = 97;
    // Width of d.d
    localparam int unsigned DD_W  = 64;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTRE_X   = 3'd0,
        REG_CENTRE_Y   = 3'd1,
        REG_CENTRE_Z   = 3'd2,
        REG_RADIUS     = 3'd3,
        REG_SPHERE_VX  = 3'd4,
        REG_SPHERE_VY  = 3'd5,
        REG_SPHERE_VZ  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][31:0] centre;
        logic [30:0]      radius;
        logic [2:0][31:0] svel;
    } cfg_t;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
    } item_t;

    // Fields that ride along the whole pipeline
    typedef struct packed {
        logic [2:0][31:0] vel;
        logic [2:0]       dpos;
        logic [2:0]       dneg;
        logic             hit;
        logic             refl;
    } side_t;

    typedef struct packed {
        logic [DD_W-1:0]  dd;
        logic [63:0]      awd;
        logic [2:0][30:0] magd;
        side_t            side;
    } geom_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] num;
        logic [DD_W-1:0]       dd;
        side_t                 side;
    } scale_t;

    typedef struct packed {
        logic [2:0][QBITS-1:0] q;
        side_t                 side;
    } quot_t;

endpackage
`default_nettype wire

// ----- design/scs_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scs_ifs
// Valid/ready channels for particle words in and velocity words out.
// ----------------------------------------------------------------------------
interface scs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_in_x;
    logic [31:0] vel_in_y;
    logic [31:0] vel_in_z;

    modport source (output valid, pos_x, pos_y, pos_z, vel_in_x, vel_in_y, vel_in_z,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, vel_in_x, vel_in_y, vel_in_z,
                    output ready);
endinterface

interface scs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] vel_out_x;
    logic [31:0] vel_out_y;
    logic [31:0] vel_out_z;
    logic        inside_res;
    logic        reflected;
    logic        saturated;

    modport source (output valid, vel_out_x, vel_out_y, vel_out_z, inside_res,
                    reflected, saturated, input ready);
    modport sink   (input valid, vel_out_x, vel_out_y, vel_out_z, inside_res,
                    reflected, saturated, output ready);
endinterface
`default_nettype wire

// ----- design/scs_geom.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scs_geom
// Three stages: offsets, products, then d.d, w.d and the inside test.
// ----------------------------------------------------------------------------
module scs_geom
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire scs_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire scs_pkg::item_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output scs_pkg::geom_t      out_data
);

    logic va_reg, vb_reg, vc_reg;
    logic rdy_a, rdy_b, rdy_c;

    // stage A registers
    logic signed [2:0][32:0] d_a_reg, w_a_reg;
    logic [2:0][30:0]        magd_a_reg;
    logic                    near_a_reg;
    scs_pkg::side_t          side_a_reg;
    // stage B registers
    logic [2:0][61:0]        sq_b_reg;
    logic [2:0][65:0]        p_b_reg;
    logic [61:0]             r2_b_reg;
    logic [2:0][30:0]        magd_b_reg;
    logic                    near_b_reg;
    scs_pkg::side_t          side_b_reg;
    // stage C register
    scs_pkg::geom_t          geom_c_reg;

    logic signed [2:0][32:0] d_next, w_next;
    logic [2:0][32:0]        mag_next;
    logic [2:0][30:0]        magd_next;
    logic                    near_next;
    scs_pkg::side_t          side_next;
    logic [2:0][61:0]        sq_next;
    logic [2:0][65:0]        p_next;
    scs_pkg::geom_t          geom_next;
    logic [66:0]             wd_sum;
    logic [66:0]             wd_abs;

    // stall chain: a stage takes a word when it is empty or moves on
    assign rdy_c    = !vc_reg || out_ready;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    // offsets, relative velocity, per-axis radius check
    always_comb
    begin
        near_next = 1'b1;
        side_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            d_next[i] = $signed({in_data.pos[i][31], in_data.pos[i]})
                      - $signed({cfg.centre[i][31], cfg.centre[i]});
            w_next[i] = $signed({in_data.vel[i][31], in_data.vel[i]})
                      - $signed({cfg.svel[i][31], cfg.svel[i]});
            mag_next[i] = d_next[i][32] ? 33'(-d_next[i]) : 33'(d_next[i]);
            magd_next[i] = mag_next[i][30:0];
            if (mag_next[i] >= {2'b00, cfg.radius})
            begin
                near_next = 1'b0;
            end
            side_next.vel[i]  = in_data.vel[i];
            side_next.dneg[i] = d_next[i][32];
            side_next.dpos[i] = !d_next[i][32] && (d_next[i] != '0);
        end
    end

    // squares and signed dot-product terms
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = magd_a_reg[i] * magd_a_reg[i];
            p_next[i]  = 66'($signed(d_a_reg[i]) * $signed(w_a_reg[i]));
        end
    end

    // sums, inside test, magnitude of w.d
    always_comb
    begin
        geom_next      = '0;
        geom_next.dd   = 64'(sq_b_reg[0]) + 64'(sq_b_reg[1]) + 64'(sq_b_reg[2]);
        wd_sum         = {p_b_reg[0][65], p_b_reg[0]} + {p_b_reg[1][65], p_b_reg[1]}
                       + {p_b_reg[2][65], p_b_reg[2]};
        wd_abs         = wd_sum[66] ? (~wd_sum + 67'd1) : wd_sum;
        geom_next.awd  = wd_abs[63:0];
        geom_next.magd = magd_b_reg;
        geom_next.side = side_b_reg;
        geom_next.side.hit  = near_b_reg && (geom_next.dd != '0)
                            && (geom_next.dd < {2'b00, r2_b_reg});
        geom_next.side.refl = geom_next.side.hit && wd_sum[66];
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a) va_reg <= in_valid;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            d_a_reg    <= d_next;
            w_a_reg    <= w_next;
            magd_a_reg <= magd_next;
            near_a_reg <= near_next;
            side_a_reg <= side_next;
        end
        if (rdy_b)
        begin
            sq_b_reg   <= sq_next;
            p_b_reg    <= p_next;
            r2_b_reg   <= cfg.radius * cfg.radius;
            magd_b_reg <= magd_a_reg;
            near_b_reg <= near_a_reg;
            side_b_reg <= side_a_reg;
        end
        if (rdy_c)
        begin
            geom_c_reg <= geom_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_data  = geom_c_reg;

endmodule
`default_nettype wire

// ----- design/scs_scale.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scs_scale
// Two stages: split products of |w.d| by 2|d_i|, then the 96-bit numerators.
// ----------------------------------------------------------------------------
module scs_scale
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire scs_pkg::geom_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output scs_pkg::scale_t     out_data
);

    logic vd_reg, ve_reg;
    logic rdy_d, rdy_e;

    logic [2:0][63:0]          pl_reg, ph_reg;
    logic [scs_pkg::DD_W-1:0]  dd_d_reg;
    scs_pkg::side_t            side_d_reg;
    scs_pkg::scale_t           scale_e_reg;
    scs_pkg::scale_t           scale_next;

    assign rdy_e    = !ve_reg || out_ready;
    assign rdy_d    = !vd_reg || rdy_e;
    assign in_ready = rdy_d;

    // join the partial products
    always_comb
    begin
        scale_next      = '0;
        scale_next.dd   = dd_d_reg;
        scale_next.side = side_d_reg;
        for (int i = 0; i < 3; i++)
        begin
            scale_next.num[i] = scs_pkg::NUM_W'(pl_reg[i])
                              + (scs_pkg::NUM_W'(ph_reg[i]) << 32);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            if (rdy_d) vd_reg <= in_valid;
            if (rdy_e) ve_reg <= vd_reg;
        end
    end

    // 64x32 product as two 32x32 halves
    always_ff @(posedge clk)
    begin
        if (rdy_d)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i] <= in_data.awd[31:0]  * {in_data.magd[i], 1'b0};
                ph_reg[i] <= in_data.awd[63:32] * {in_data.magd[i], 1'b0};
            end
            dd_d_reg   <= in_data.dd;
            side_d_reg <= in_data.side;
        end
        if (rdy_e)
        begin
            scale_e_reg <= scale_next;
        end
    end

    assign out_valid = ve_reg;
    assign out_data  = scale_e_reg;

endmodule
`default_nettype wire

// ----- design/scs_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scs_divider
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing the divisor d.d.
// ----------------------------------------------------------------------------
module scs_divider
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire scs_pkg::scale_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output scs_pkg::quot_t       out_data
);

    localparam int unsigned QB = scs_pkg::QBITS;
    localparam int unsigned NW = scs_pkg::NUM_W;

    logic [QB-1:0]                  valid_reg;
    logic [QB:0]                    rdy;
    logic [2:0][NW-1:0]             rem_reg  [QB];
    logic [2:0][QB-1:0]             q_reg    [QB];
    logic [scs_pkg::DD_W-1:0]       dd_reg   [QB];
    scs_pkg::side_t                 side_reg [QB];

    assign rdy[QB]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar j = 0; j < QB; j++)
    begin : g_step
        localparam int unsigned SH = QB - 1 - j;

        logic [2:0][NW-1:0]       rem_in, rem_next;
        logic [2:0][QB-1:0]       q_in, q_next;
        logic [scs_pkg::DD_W-1:0] dd_in;
        scs_pkg::side_t           side_in;
        logic                     vld_in;
        logic [NW-1:0]            trial;

        if (j == 0)
        begin : g_first
            assign rem_in  = in_data.num;
            assign q_in    = '0;
            assign dd_in   = in_data.dd;
            assign side_in = in_data.side;
            assign vld_in  = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign dd_in   = dd_reg[j-1];
            assign side_in = side_reg[j-1];
            assign vld_in  = valid_reg[j-1];
        end

        assign rdy[j] = !valid_reg[j] || rdy[j+1];
        assign trial  = NW'(dd_in) << SH;

        // subtract the shifted divisor where it fits
        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (rem_in[l] >= trial)
                begin
                    rem_next[l] = rem_in[l] - trial;
                    q_next[l]   = q_in[l] | (QB'(1) << SH);
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                    q_next[l]   = q_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (rdy[j])
            begin
                valid_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j])
            begin
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                dd_reg[j]   <= dd_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid     = valid_reg[QB-1];
    assign out_data.q    = q_reg[QB-1];
    assign out_data.side = side_reg[QB-1];

endmodule
`default_nettype wire

// ----- design/sphere_collision_velocity_reflect.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_collision_velocity_reflect
// Reflects particle velocities off a moving sphere set by APB registers.
// ----------------------------------------------------------------------------
// The block takes one particle word per clock while the output is not stalled
// and returns one velocity word per particle, in order, after three stages for
// the offsets, products and inside test, two for the wide products, 35 for the
// bit-per-stage divider that forms 2|w.d||d_i|/(d.d), and one for the
// correction and clamp. The divider depth sets the latency; throughput is one
// word per clock whenever the output side takes words. Registers (byte
// address 4*i): centre x/y/z, radius (31 bits), sphere velocity x/y/z; write
// them only while the pipeline is empty. All Q16.16, signed but the radius.
// ----------------------------------------------------------------------------
module sphere_collision_velocity_reflect
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    scs_in_if.sink           in_ch,
    scs_out_if.source        out_ch
);

    scs_pkg::cfg_t   cfg_reg;
    scs_pkg::item_t  item;
    scs_pkg::geom_t  geom;
    scs_pkg::scale_t scale;
    scs_pkg::quot_t  quot;
    logic            geom_valid, geom_ready;
    logic            scale_valid, scale_ready;
    logic            quot_valid, quot_ready;
    logic            wr_en;

    logic             ovalid_reg;
    logic [2:0][31:0] vout_reg;
    logic             inside_reg, refl_reg, sat_reg;
    logic [2:0][31:0] vout_next;
    logic             sat_next;
    logic [2:0][36:0] r_ext;

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (scs_pkg::reg_idx_t'(paddr[4:2]))
                scs_pkg::REG_CENTRE_X:  cfg_reg.centre[0] <= pwdata;
                scs_pkg::REG_CENTRE_Y:  cfg_reg.centre[1] <= pwdata;
                scs_pkg::REG_CENTRE_Z:  cfg_reg.centre[2] <= pwdata;
                scs_pkg::REG_RADIUS:    cfg_reg.radius    <= pwdata[30:0];
                scs_pkg::REG_SPHERE_VX: cfg_reg.svel[0]   <= pwdata;
                scs_pkg::REG_SPHERE_VY: cfg_reg.svel[1]   <= pwdata;
                scs_pkg::REG_SPHERE_VZ: cfg_reg.svel[2]   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (scs_pkg::reg_idx_t'(paddr[4:2]))
            scs_pkg::REG_CENTRE_X:  prdata = cfg_reg.centre[0];
            scs_pkg::REG_CENTRE_Y:  prdata = cfg_reg.centre[1];
            scs_pkg::REG_CENTRE_Z:  prdata = cfg_reg.centre[2];
            scs_pkg::REG_RADIUS:    prdata = {1'b0, cfg_reg.radius};
            scs_pkg::REG_SPHERE_VX: prdata = cfg_reg.svel[0];
            scs_pkg::REG_SPHERE_VY: prdata = cfg_reg.svel[1];
            scs_pkg::REG_SPHERE_VZ: prdata = cfg_reg.svel[2];
            default:                prdata = '0;
        endcase
    end

    // pack the input word
    assign item.pos = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
    assign item.vel = {in_ch.vel_in_z, in_ch.vel_in_y, in_ch.vel_in_x};

    scs_geom u_geom
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (item),
        .out_valid (geom_valid),
        .out_ready (geom_ready),
        .out_data  (geom)
    );

    scs_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_ready  (geom_ready),
        .in_data   (geom),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_data  (scale)
    );

    scs_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_data   (scale),
        .out_valid (quot_valid),
        .out_ready (quot_ready),
        .out_data  (quot)
    );

    // apply the correction along the sign of d_i and clamp
    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            r_ext[i] = {{5{quot.side.vel[i][31]}}, quot.side.vel[i]};
            if (quot.side.refl && quot.side.dpos[i])
            begin
                r_ext[i] = r_ext[i] + {2'b00, quot.q[i]};
            end
            else if (quot.side.refl && quot.side.dneg[i])
            begin
                r_ext[i] = r_ext[i] - {2'b00, quot.q[i]};
            end
            if (!r_ext[i][36] && (r_ext[i][35:31] != 5'h00))
            begin
                vout_next[i] = 32'h7FFF_FFFF;
                sat_next     = 1'b1;
            end
            else if (r_ext[i][36] && (r_ext[i][35:31] != 5'h1F))
            begin
                vout_next[i] = 32'h8000_0000;
                sat_next     = 1'b1;
            end
            else
            begin
                vout_next[i] = r_ext[i][31:0];
            end
        end
    end

    // output register
    assign quot_ready = !ovalid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (quot_ready)
        begin
            ovalid_reg <= quot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (quot_ready)
        begin
            vout_reg   <= vout_next;
            inside_reg <= quot.side.hit;
            refl_reg   <= quot.side.refl;
            sat_reg    <= sat_next;
        end
    end

    assign out_ch.valid      = ovalid_reg;
    assign out_ch.vel_out_x  = vout_reg[0];
    assign out_ch.vel_out_y  = vout_reg[1];
    assign out_ch.vel_out_z  = vout_reg[2];
    assign out_ch.inside_res = inside_reg;
    assign out_ch.reflected  = refl_reg;
    assign out_ch.saturated  = sat_reg;

    // a reflection needs the particle inside; clamping happens only on reflection
    a_refl_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.reflected |-> out_ch.inside_res)
        else $error("reflected word outside the sphere");

    a_sat_refl: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.saturated |-> out_ch.reflected)
        else $error("clamp without reflection");

    // a word leaving the divider always finds room when the output is free
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        quot_valid && !ovalid_reg |=> ovalid_reg)
        else $error("divider word lost at output register");

endmodule
`default_nettype wire

// ----- verif/sphere_collision_velocity_reflect_tb.sv -----
// ----------------------------------------------------------------------------
// sphere_collision_velocity_reflect_tb
// Streams particle words into the sphere reflection pipeline, predicts each
// velocity word with an exact wide-integer model, and compares every output
// word in order. Registers are set over APB between phases of traffic.
// ----------------------------------------------------------------------------
module sphere_collision_velocity_reflect_tb;

    localparam int LATENCY   = 41;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [31:0] px, py, pz, vx, vy, vz;
    } particle_t;

    typedef struct packed {
        logic [31:0] ox, oy, oz;
        logic        ins, refl, sat;
    } vel_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    scs_in_if  in_ch ();
    scs_out_if out_ch ();

    sphere_collision_velocity_reflect DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    // Shadow copy of the sphere registers
    logic signed [31:0] sh_centre [3];
    logic        [30:0] sh_radius;
    logic signed [31:0] sh_svel [3];

    particle_t pending_particles [$];
    vel_word_t expected_vel [$];

    int  idle_src_pct;
    int  idle_snk_pct;
    int  hold_off_cycles;
    int  errors;
    int  words_in;
    int  words_out;
    int  reflect_count;
    int  sat_count;
    int  quiet_cycles;

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Predict one velocity word from a particle and the shadow registers
    function automatic vel_word_t reflect_velocity(particle_t p);
        vel_word_t              r;
        logic signed [33:0]     d [3];
        logic signed [33:0]     w [3];
        logic signed [33:0]     v [3];
        logic signed [127:0]    wd;
        logic        [127:0]    awd;
        logic        [127:0]    dd;
        logic        [127:0]    rr;
        logic        [127:0]    q;
        logic        [33:0]     md;
        logic signed [63:0]     res;
        logic                   ins;
        d[0] = $signed(p.px) - sh_centre[0];
        d[1] = $signed(p.py) - sh_centre[1];
        d[2] = $signed(p.pz) - sh_centre[2];
        v[0] = $signed(p.vx);
        v[1] = $signed(p.vy);
        v[2] = $signed(p.vz);
        r = '0;
        r.ox = p.vx;
        r.oy = p.vy;
        r.oz = p.vz;
        dd = '0;
        wd = '0;
        for (int i = 0; i < 3; i++)
        begin
            w[i] = v[i] - sh_svel[i];
            dd = dd + 128'(d[i] * d[i]);
            wd = wd + 128'(w[i] * d[i]);
        end
        rr = 128'(sh_radius) * 128'(sh_radius);
        ins = (dd != 0) && (dd < rr);
        r.ins = ins;
        // Reflect only when approaching
        if (ins && wd < 0)
        begin
            r.refl = 1'b1;
            awd = -wd;
            for (int i = 0; i < 3; i++)
            begin
                md = d[i] < 0 ? 34'(-d[i]) : 34'(d[i]);
                q = (awd * 128'(md) * 2) / dd;
                if (d[i] > 0)
                    res = 64'(v[i]) + 64'(q);
                else if (d[i] < 0)
                    res = 64'(v[i]) - 64'(q);
                else
                    res = 64'(v[i]);
                if (res > 64'sh7FFFFFFF)
                begin
                    res = 64'sh7FFFFFFF;
                    r.sat = 1'b1;
                end
                else if (res < -64'sh80000000)
                begin
                    res = -64'sh80000000;
                    r.sat = 1'b1;
                end
                if (i == 0) r.ox = res[31:0];
                if (i == 1) r.oy = res[31:0];
                if (i == 2) r.oz = res[31:0];
            end
        end
        return r;
    endfunction

    // APB register write: setup then access
    task automatic write_reg(scs_pkg::reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            scs_pkg::REG_CENTRE_X:  sh_centre[0] = val;
            scs_pkg::REG_CENTRE_Y:  sh_centre[1] = val;
            scs_pkg::REG_CENTRE_Z:  sh_centre[2] = val;
            scs_pkg::REG_RADIUS:    sh_radius    = val[30:0];
            scs_pkg::REG_SPHERE_VX: sh_svel[0]   = val;
            scs_pkg::REG_SPHERE_VY: sh_svel[1]   = val;
            scs_pkg::REG_SPHERE_VZ: sh_svel[2]   = val;
            default: ;
        endcase
    endtask

    task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] rad, logic [31:0] wx, logic [31:0] wy,
                              logic [31:0] wz);
        write_reg(scs_pkg::REG_CENTRE_X, cx);
        write_reg(scs_pkg::REG_CENTRE_Y, cy);
        write_reg(scs_pkg::REG_CENTRE_Z, cz);
        write_reg(scs_pkg::REG_RADIUS, rad);
        write_reg(scs_pkg::REG_SPHERE_VX, wx);
        write_reg(scs_pkg::REG_SPHERE_VY, wy);
        write_reg(scs_pkg::REG_SPHERE_VZ, wz);
    endtask

    // Wait for the pipeline to drain completely
    task automatic drain();
        while (pending_particles.size() != 0 || expected_vel.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 400)) - 200);
            default: return $urandom;
        endcase
    endfunction

    // Offset around the centre scaled so most particles land near the sphere
    function automatic logic [31:0] near(logic [31:0] c, int unsigned span);
        logic signed [31:0] off;
        off = $signed($urandom_range(0, 2 * span)) - $signed(span);
        return c + off;
    endfunction

    task automatic queue_particle(particle_t p);
        pending_particles.insert(pending_particles.size(), p);
    endtask

    task automatic queue_random(int n, int unsigned span, bit flat);
        particle_t p;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                p.px = near(sh_centre[0], span);
                p.py = near(sh_centre[1], span);
                p.pz = flat ? sh_centre[2] : near(sh_centre[2], span);
                p.vx = $urandom_range(0, 3) == 0 ? rand_word() : near(sh_svel[0], span);
                p.vy = $urandom_range(0, 3) == 0 ? rand_word() : near(sh_svel[1], span);
                p.vz = flat ? 32'd0 : near(sh_svel[2], span);
            end
            else
            begin
                p = {rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word()};
            end
            queue_particle(p);
        end
    endtask

    // Driver: offer the oldest pending word, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid    <= 1'b0;
            in_ch.pos_x    <= '0;
            in_ch.pos_y    <= '0;
            in_ch.pos_z    <= '0;
            in_ch.vel_in_x <= '0;
            in_ch.vel_in_y <= '0;
            in_ch.vel_in_z <= '0;
        end
        else
        begin
            particle_t nxt;
            logic      taken;
            taken = in_ch.valid && in_ch.ready;
            if (taken)
            begin
                expected_vel.insert(expected_vel.size(),
                                    reflect_velocity(pending_particles.pop_front()));
                words_in++;
            end
            if (!in_ch.valid || taken)
            begin
                if (pending_particles.size() != 0 &&
                    $urandom_range(0, 99) >= idle_src_pct)
                begin
                    nxt = pending_particles[0];
                    in_ch.valid    <= 1'b1;
                    in_ch.pos_x    <= nxt.px;
                    in_ch.pos_y    <= nxt.py;
                    in_ch.pos_z    <= nxt.pz;
                    in_ch.vel_in_x <= nxt.vx;
                    in_ch.vel_in_y <= nxt.vy;
                    in_ch.vel_in_z <= nxt.vz;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver ready: random stalls plus an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ch.ready    <= 1'b0;
        end
        else
            out_ch.ready <= $urandom_range(0, 99) >= idle_snk_pct;
    end

    // Monitor: compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            vel_word_t got;
            vel_word_t exp_w;
            got = {out_ch.vel_out_x, out_ch.vel_out_y, out_ch.vel_out_z,
                   out_ch.inside_res, out_ch.reflected, out_ch.saturated};
            words_out++;
            if (expected_vel.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                exp_w = expected_vel.pop_front();
                if (got.refl) reflect_count++;
                if (got.sat) sat_count++;
                if (got.ox !== exp_w.ox)
                begin
                    $display("%0t: vel_out_x exp %h got %h", $time, exp_w.ox, got.ox);
                    errors++;
                end
                if (got.oy !== exp_w.oy)
                begin
                    $display("%0t: vel_out_y exp %h got %h", $time, exp_w.oy, got.oy);
                    errors++;
                end
                if (got.oz !== exp_w.oz)
                begin
                    $display("%0t: vel_out_z exp %h got %h", $time, exp_w.oz, got.oz);
                    errors++;
                end
                if (got.ins !== exp_w.ins)
                begin
                    $display("%0t: inside_res exp %b got %b", $time, exp_w.ins, got.ins);
                    errors++;
                end
                if (got.refl !== exp_w.refl)
                begin
                    $display("%0t: reflected exp %b got %b", $time, exp_w.refl, got.refl);
                    errors++;
                end
                if (got.sat !== exp_w.sat)
                begin
                    $display("%0t: saturated exp %b got %b", $time, exp_w.sat, got.sat);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (pending_particles.size() == 0 && expected_vel.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("%0t: watchdog expired, %0d words outstanding", $time,
                     expected_vel.size());
            $display("sphere_collision_velocity_reflect_tb: errors");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        words_in = 0;
        words_out = 0;
        reflect_count = 0;
        sat_count = 0;
        quiet_cycles = 0;
        hold_off_cycles = 0;
        idle_src_pct = 28;
        idle_snk_pct = 79;
        for (int i = 0; i < 3; i++)
        begin
            sh_centre[i] = '0;
            sh_svel[i] = '0;
        end
        sh_radius = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Radius zero after reset: nothing is ever inside
        queue_particle({32'd1, 32'd0, 32'd0, 32'hFFFF0000, 32'd0, 32'd0});
        queue_particle({32'h7FFFFFFF, 32'h80000000, 32'd0, 32'h7FFFFFFF, 32'h80000000,
                        32'hFFFFFFFF});
        drain();

        // Directed cases: unit sphere at the origin, still
        set_sphere(32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0);
        // zero offset, approaching, receding, tangent, zero relative velocity
        queue_particle({32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0});
        queue_particle({32'h0000_8000, 32'd0, 32'd0, 32'hFFFF_0000, 32'd0, 32'd0});
        queue_particle({32'h0000_8000, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0});
        queue_particle({32'h0000_8000, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0});
        queue_particle({32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 32'd0, 32'd0,
                        32'd0});
        queue_particle({32'h0001_0000, 32'd0, 32'd0, 32'hFFFF_0000, 32'd0, 32'd0});
        queue_particle({32'hFFFF_8000, 32'hFFFF_C000, 32'h0000_2000, 32'h0003_0000,
                        32'h0002_0000, 32'hFFFF_0000});
        // saturating corrections at both ends
        queue_particle({32'h0000_8000, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0});
        queue_particle({32'hFFFF_8000, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0});
        queue_particle({32'h0000_1000, 32'hFFFF_F000, 32'd1, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000});
        drain();

        // Widest radius, centre and sphere velocity at extremes
        set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_particle({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000});
        queue_particle({32'h8000_0001, 32'h7FFF_FFFE, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000});
        queue_particle({32'hC000_0000, 32'h4000_0000, 32'hC000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h0000_0000});
        queue_random(300, 32'h4000_0000, 1'b0);
        idle_src_pct = 28;
        idle_snk_pct = 79;
        drain();

        // Moving sphere, 3D, receiver-heavy stalls
        set_sphere(32'h0010_0000, 32'hFFF0_0000, 32'h0003_0000, 32'h0004_0000,
                   32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000);
        queue_random(450, 32'h0005_0000, 1'b0);
        drain();

        // 2D use with the idling swapped
        idle_src_pct = 79;
        idle_snk_pct = 28;
        set_sphere(32'hFF00_0000, 32'h0100_0000, 32'd0, 32'h0080_0000,
                   32'hFFF0_0000, 32'h0020_0000, 32'd0);
        queue_random(450, 32'h00A0_0000, 1'b1);
        drain();

        // Full speed, with one long hold-off so the pipeline backs up
        idle_src_pct = 0;
        idle_snk_pct = 0;
        set_sphere(32'd0, 32'd0, 32'd0, 32'h0000_0100, 32'd1, 32'hFFFF_FFFF, 32'd0);
        queue_random(500, 32'h0000_0140, 1'b0);
        repeat (20) @(posedge clk);
        hold_off_cycles = 300;
        drain();

        $display("covered %0d particle words, %0d velocity words, %0d reflected, %0d clamped",
                 words_in, words_out, reflect_count, sat_count);
        $display("sphere configurations: reset, unit, extreme, 3D moving, 2D, tiny");
        if (errors == 0)
            $display("sphere_collision_velocity_reflect_tb: clean");
        else
            $display("sphere_collision_velocity_reflect_tb: errors");
        $finish;
    end
endmodule
